>>> sv/rrpw_pkg.sv
// shared types, constants and register codes for the rear radar proximity warner
`default_nettype none

package rrpw_pkg;

  // field widths
  localparam int unsigned DIST_W     = 17;
  localparam int unsigned SPEED_W    = 16;
  localparam int unsigned COUNT_W    = 8;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 17;

  // frame limits
  localparam logic [DIST_W-1:0]  FAR_DISTANCE = DIST_W'(99900);
  localparam logic [COUNT_W-1:0] COUNT_CAP    = COUNT_W'(255);
  localparam logic [COUNT_W-1:0] MAX_TARGETS  = COUNT_W'(8);

  // register reset values
  localparam logic signed [SPEED_W-1:0] FAST_LIMIT_RST = SPEED_W'(-150);
  localparam logic [DIST_W-1:0]  ATTENTION_RST = DIST_W'(300);
  localparam logic [DIST_W-1:0]  WARNING_RST   = DIST_W'(150);
  localparam logic [DIST_W-1:0]  DANGER_RST    = DIST_W'(50);
  localparam logic [COUNT_W-1:0] SETTLE_RST    = COUNT_W'(3);

  // register indexes on the config port
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FAST_SPEED_LIMIT   = 3'd0,
    CFG_ATTENTION_DISTANCE = 3'd1,
    CFG_WARNING_DISTANCE   = 3'd2,
    CFG_DANGER_DISTANCE    = 3'd3,
    CFG_SETTLE_FRAMES      = 3'd4
  } cfg_idx_e;

  // danger classes
  typedef enum logic [1:0] {
    LVL_SAFE      = 2'd0,
    LVL_ATTENTION = 2'd1,
    LVL_WARNING   = 2'd2,
    LVL_DANGER    = 2'd3
  } danger_level_e;

  // current register contents
  typedef struct packed {
    logic signed [SPEED_W-1:0] fast_speed_limit;
    logic [DIST_W-1:0]         attention_distance;
    logic [DIST_W-1:0]         warning_distance;
    logic [DIST_W-1:0]         danger_distance;
    logic [COUNT_W-1:0]        settle_frames;
  } cfg_t;

  // one input beat held in the input register
  typedef struct packed {
    logic                      target_valid;
    logic [DIST_W-1:0]         target_distance;
    logic signed [SPEED_W-1:0] target_speed;
    logic                      frame_last;
  } target_t;

  // frame summary handed from the accumulator to the evaluator
  typedef struct packed {
    logic                      valid;
    logic [DIST_W-1:0]         min_distance;
    logic signed [SPEED_W-1:0] min_speed;
  } frame_end_t;

endpackage

`default_nettype wire

>>> sv/rrpw_if.sv
// valid/ready channel interfaces for target and result beats
`default_nettype none

interface rrpw_target_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 target_valid;
  logic [rrpw_pkg::DIST_W-1:0]          target_distance;
  logic signed [rrpw_pkg::SPEED_W-1:0]  target_speed;
  logic                                 frame_last;

  modport source (
    output valid, target_valid, target_distance, target_speed, frame_last,
    input  ready
  );
  modport sink (
    input  valid, target_valid, target_distance, target_speed, frame_last,
    output ready
  );
endinterface

interface rrpw_result_if;
  logic                                 valid;
  logic                                 ready;
  logic [1:0]                           danger_level;
  logic [rrpw_pkg::DIST_W-1:0]          nearest_distance;
  logic signed [rrpw_pkg::SPEED_W-1:0]  closing_speed;
  logic                                 approaching_fast;

  modport source (
    output valid, danger_level, nearest_distance, closing_speed, approaching_fast,
    input  ready
  );
  modport sink (
    input  valid, danger_level, nearest_distance, closing_speed, approaching_fast,
    output ready
  );
endinterface

`default_nettype wire

>>> sv/rrpw_cfg_regs.sv
// configuration register file, write only
`default_nettype none

module rrpw_cfg_regs (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [rrpw_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [rrpw_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  output rrpw_pkg::cfg_t                          cfg_o
);

  rrpw_pkg::cfg_t cfg_q, cfg_d;

  // decode the write, unknown indexes leave everything alone
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (rrpw_pkg::cfg_idx_e'(cfg_index_i))
        rrpw_pkg::CFG_FAST_SPEED_LIMIT: begin
          cfg_d.fast_speed_limit = cfg_data_i[rrpw_pkg::SPEED_W-1:0];
        end
        rrpw_pkg::CFG_ATTENTION_DISTANCE: begin
          cfg_d.attention_distance = cfg_data_i[rrpw_pkg::DIST_W-1:0];
        end
        rrpw_pkg::CFG_WARNING_DISTANCE: begin
          cfg_d.warning_distance = cfg_data_i[rrpw_pkg::DIST_W-1:0];
        end
        rrpw_pkg::CFG_DANGER_DISTANCE: begin
          cfg_d.danger_distance = cfg_data_i[rrpw_pkg::DIST_W-1:0];
        end
        rrpw_pkg::CFG_SETTLE_FRAMES: begin
          cfg_d.settle_frames = cfg_data_i[rrpw_pkg::COUNT_W-1:0];
        end
        default: begin
          cfg_d = cfg_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fast_speed_limit   <= rrpw_pkg::FAST_LIMIT_RST;
      cfg_q.attention_distance <= rrpw_pkg::ATTENTION_RST;
      cfg_q.warning_distance   <= rrpw_pkg::WARNING_RST;
      cfg_q.danger_distance    <= rrpw_pkg::DANGER_RST;
      cfg_q.settle_frames      <= rrpw_pkg::SETTLE_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

>>> sv/rrpw_frame_acc.sv
// input register and per-frame running minimum of distance and speed
`default_nettype none

module rrpw_frame_acc (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  rrpw_target_if.sink          tgt_i,
  input  wire logic            eval_free_i,
  output rrpw_pkg::frame_end_t frame_end_o
);

  rrpw_pkg::target_t                    item_q;
  logic                                 item_vld_q;
  logic [rrpw_pkg::DIST_W-1:0]          min_dist_q, min_dist_d;
  logic signed [rrpw_pkg::SPEED_W-1:0]  min_speed_q, min_speed_d;
  logic [rrpw_pkg::COUNT_W-1:0]         seen_q, seen_d;
  logic                                 counted;
  logic                                 fire;
  logic                                 take;

  // a held beat moves on unless it ends a frame and the result side is full
  assign fire        = item_vld_q && (!item_q.frame_last || eval_free_i);
  assign tgt_i.ready = !item_vld_q || fire;
  assign take        = tgt_i.valid && tgt_i.ready;

  // fold the held target into the running values
  always_comb begin
    counted     = item_q.target_valid && (seen_q < rrpw_pkg::MAX_TARGETS);
    min_dist_d  = min_dist_q;
    min_speed_d = min_speed_q;
    seen_d      = seen_q;
    if (counted) begin
      if (item_q.target_distance < min_dist_q) begin
        min_dist_d = item_q.target_distance;
      end
      if ($signed(item_q.target_speed) < $signed(min_speed_q)) begin
        min_speed_d = item_q.target_speed;
      end
      seen_d = seen_q + rrpw_pkg::COUNT_W'(1);
    end
  end

  assign frame_end_o.valid        = item_vld_q && item_q.frame_last;
  assign frame_end_o.min_distance = min_dist_d;
  assign frame_end_o.min_speed    = min_speed_d;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
    end else if (take) begin
      item_vld_q <= 1'b1;
    end else if (fire) begin
      item_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q.target_valid    <= tgt_i.target_valid;
      item_q.target_distance <= tgt_i.target_distance;
      item_q.target_speed    <= tgt_i.target_speed;
      item_q.frame_last      <= tgt_i.frame_last;
    end
  end

  // running frame state, cleared once the frame end leaves
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_dist_q  <= rrpw_pkg::FAR_DISTANCE;
      min_speed_q <= '0;
      seen_q      <= '0;
    end else if (fire) begin
      if (item_q.frame_last) begin
        min_dist_q  <= rrpw_pkg::FAR_DISTANCE;
        min_speed_q <= '0;
        seen_q      <= '0;
      end else begin
        min_dist_q  <= min_dist_d;
        min_speed_q <= min_speed_d;
        seen_q      <= seen_d;
      end
    end
  end

endmodule

`default_nettype wire

>>> sv/rrpw_frame_eval.sv
// danger classification, fast-approach debounce and result register
`default_nettype none

module rrpw_frame_eval (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire rrpw_pkg::cfg_t       cfg_i,
  input  wire rrpw_pkg::frame_end_t frame_end_i,
  output logic                      eval_free_o,
  rrpw_result_if.source             res_o
);

  rrpw_pkg::danger_level_e        level;
  logic                           raw_fast;
  logic                           pending_q, pending_d;
  logic [rrpw_pkg::COUNT_W-1:0]   stable_q, stable_d;
  logic                           flag_q, flag_d;
  logic                           take_end;
  logic                           res_vld_q;
  logic [1:0]                     level_q;
  logic [rrpw_pkg::DIST_W-1:0]    dist_q;
  logic [rrpw_pkg::SPEED_W-1:0]   speed_q;

  assign eval_free_o = !res_vld_q || res_o.ready;
  assign take_end    = frame_end_i.valid && eval_free_o;

  // thresholds tested from the closest band outward
  always_comb begin
    priority if (frame_end_i.min_distance <= cfg_i.danger_distance) begin
      level = rrpw_pkg::LVL_DANGER;
    end else if (frame_end_i.min_distance <= cfg_i.warning_distance) begin
      level = rrpw_pkg::LVL_WARNING;
    end else if (frame_end_i.min_distance <= cfg_i.attention_distance) begin
      level = rrpw_pkg::LVL_ATTENTION;
    end else begin
      level = rrpw_pkg::LVL_SAFE;
    end
  end

  // debounce: count frames with an unchanged raw condition
  always_comb begin
    raw_fast  = $signed(frame_end_i.min_speed) <= $signed(cfg_i.fast_speed_limit);
    pending_d = pending_q;
    stable_d  = stable_q;
    if (raw_fast != pending_q) begin
      pending_d = raw_fast;
      stable_d  = '0;
    end else if (stable_q < rrpw_pkg::COUNT_CAP) begin
      stable_d = stable_q + rrpw_pkg::COUNT_W'(1);
    end
    flag_d = (stable_d >= cfg_i.settle_frames) ? pending_d : flag_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= 1'b0;
      stable_q  <= '0;
      flag_q    <= 1'b0;
    end else if (take_end) begin
      pending_q <= pending_d;
      stable_q  <= stable_d;
      flag_q    <= flag_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else if (take_end) begin
      res_vld_q <= 1'b1;
    end else if (res_o.ready) begin
      res_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_end) begin
      level_q <= level;
      dist_q  <= frame_end_i.min_distance;
      speed_q <= frame_end_i.min_speed;
    end
  end

  assign res_o.valid            = res_vld_q;
  assign res_o.danger_level     = level_q;
  assign res_o.nearest_distance = dist_q;
  assign res_o.closing_speed    = speed_q;
  assign res_o.approaching_fast = flag_q;

endmodule

`default_nettype wire

>>> sv/rear_radar_proximity_warner_core.sv
// top level of the rear radar proximity warner
//
//   channel   dir   handshake        beat
//   tgt_i     in    valid/ready      one radar target, frame_last ends a frame
//   res_o     out   valid/ready      one frame summary per frame end
//   cfg       in    cfg_we_i only    register write, no read-back
//
// one target beat per cycle unless a frame end stalls; a beat is held in the
// input register and a frame end moves on into the result register once the
// result side is free. the held result does not block intake: a new beat is
// taken while it waits, and only a second frame end stalls until the result
// is taken. reset clears frame state and the debounce and loads the register
// defaults.
`default_nettype none

module rear_radar_proximity_warner_core (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [rrpw_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [rrpw_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  rrpw_target_if.sink                           tgt_i,
  rrpw_result_if.source                         res_o
);

  rrpw_pkg::cfg_t       cfg;
  rrpw_pkg::frame_end_t frame_end;
  logic                 eval_free;

  // register file
  rrpw_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // per-frame accumulation
  rrpw_frame_acc u_frame_acc (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tgt_i       (tgt_i),
    .eval_free_i (eval_free),
    .frame_end_o (frame_end)
  );

  // classification and result
  rrpw_frame_eval u_frame_eval (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .frame_end_i (frame_end),
    .eval_free_o (eval_free),
    .res_o       (res_o)
  );

endmodule

`default_nettype wire
